@@ src/csvf_pkg.sv @@
// Shared constants, types and helper functions of the CRT scanline and vignette filter.
`default_nettype none

package csvf_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    localparam int COL_W = 9;
    localparam int ROW_W = 8;
    localparam int PIX_W = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 2'd0,
        CFG_SCANLINE = 2'd1,
        CFG_VIGNETTE = 2'd2
    } t_cfg_reg;

    localparam int COL_MAX = 2 ** COL_W - 1;
    localparam int ROW_MAX = 2 ** ROW_W - 1;
    localparam int CX = SCREEN_WIDTH / 2;
    localparam int CY = SCREEN_HEIGHT / 2;

    localparam int DX_MAX = (CX > COL_MAX - CX) ? CX : COL_MAX - CX;
    localparam int DY_MAX = (CY > ROW_MAX - CY) ? CY : ROW_MAX - CY;

    localparam int XT_W = $clog2(((CX > COL_MAX) ? CX : COL_MAX) + 1);
    localparam int YT_W = $clog2(((CY > ROW_MAX) ? CY : ROW_MAX) + 1);
    localparam int AX_W = $clog2(DX_MAX + 1);
    localparam int AY_W = $clog2(DY_MAX + 1);
    localparam int DXS_W = $clog2(DX_MAX * DX_MAX + 1);
    localparam int DYS_W = $clog2(DY_MAX * DY_MAX + 1);

    localparam int SQ_MAX = DX_MAX * DX_MAX + DY_MAX * DY_MAX;
    localparam int SQ_W   = $clog2(SQ_MAX + 1);
    localparam int DIST_W = (SQ_W + 1) / 2;
    localparam int SQE    = 2 * DIST_W;
    localparam int SQ_STG = (DIST_W + 1) / 2;

    function automatic int cisqrt(input int n);
        int r;
        r = 0;
        for (int k = 0; k < 2048; k++) begin
            if (k * k <= n) begin
                r = k;
            end
        end
        return r;
    endfunction

    localparam int MAXD_RAW = cisqrt(CX * CX + CY * CY);
    localparam int MAXD     = (MAXD_RAW == 0) ? 1 : MAXD_RAW;
    localparam int MAXD_W   = $clog2(MAXD + 1);

    localparam int CMP_W = (DIST_W + 8 > 9 + MAXD_W) ? DIST_W + 8 : 9 + MAXD_W;

    localparam int DP_W = DIST_W + 8;
    localparam int RS   = DP_W + $clog2(MAXD);
    localparam int RM   = (2 ** RS + MAXD - 1) / MAXD;
    localparam int RM_W = $clog2(RM + 1);
    localparam int PR_W = DP_W + RM_W;

    localparam int ST_SQ0 = 3;
    localparam int ST_MUL = ST_SQ0 + SQ_STG;
    localparam int ST_CMP = ST_MUL + 1;
    localparam int ST_SCL = ST_CMP + 1;
    localparam int ST_OUT = ST_SCL + 1;
    localparam int NST    = ST_OUT + 1;

    typedef struct packed {
        logic [SQE-1:0] rem;
        logic [SQE:0]   root;
    } t_sqrt;

    typedef struct packed {
        logic [PIX_W-1:0]  orig;
        logic [PIX_W-1:0]  px;
        logic [12:0]       pr;
        logic [13:0]       pg;
        logic [12:0]       pb;
        logic [AX_W-1:0]   ax;
        logic [AY_W-1:0]   ay;
        logic [DXS_W-1:0]  dxs;
        logic [DYS_W-1:0]  dys;
        t_sqrt             sq;
        logic [CMP_W-1:0]  m255;
        logic [CMP_W-1:0]  thr;
        logic [DP_W-1:0]   dp;
        logic              cond;
        logic [PR_W-1:0]   dq;
    } t_stage;

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x >> 8) + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

@@ src/csvf_ifs.sv @@
// Handshake interfaces for the pixel request, pixel result and configuration channels.
`default_nettype none

interface csvf_pix_in_if;
    logic                        valid;
    logic                        ready;
    logic [csvf_pkg::COL_W-1:0]  col;
    logic [csvf_pkg::ROW_W-1:0]  row;
    logic [csvf_pkg::PIX_W-1:0]  pixel_in;

    modport source (output valid, output col, output row, output pixel_in, input ready);
    modport sink   (input valid, input col, input row, input pixel_in, output ready);
endinterface

interface csvf_pix_out_if;
    logic                        valid;
    logic                        ready;
    logic [csvf_pkg::PIX_W-1:0]  pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

interface csvf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [csvf_pkg::CFG_IDX_W-1:0]   index;
    logic [csvf_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/crt_scanline_vignette_filter.sv @@
// CRT filter for an RGB565 pixel stream: darkening of even rows followed by a radial vignette.
//
// A pixel request on i_pix carries its column, row and RGB565 value; the processed pixel
// leaves on o_pix in request order. Both channels take an item at a clock edge where valid
// and ready are high. Registers are written over i_cfg (enable, scanline strength, vignette
// strength), which is always ready; write them only while no pixel is in flight.
// The datapath is a pipeline of NST register stages, twelve at the default screen size:
// input and scanline multiply, squares and scanline divide, sum of squares, one stage per
// two root digits of the integer square root, threshold and darken products, reciprocal
// multiply for the divide by the radius, vignette multiply, and the output register.
// One pixel can enter on every clock while o_pix is not stalled.
// Each stage holds its item while the next one is full and stalled, so a stall on o_pix
// fills the bubbles first and then holds i_pix.ready low; nothing is lost or repeated.
// Reset empties the pipeline and loads enable 0, scanline strength 80, vignette strength 60.
`default_nettype none

module crt_scanline_vignette_filter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    csvf_pix_in_if.sink        i_pix,
    csvf_pix_out_if.source     o_pix,
    csvf_cfg_if.sink           i_cfg
);

    logic       r_enable;
    logic [7:0] r_scan;
    logic [7:0] r_vig;

    logic [csvf_pkg::NST-1:0] r_v;
    logic [csvf_pkg::NST-1:0] ld;
    csvf_pkg::t_stage         r_st [csvf_pkg::NST];
    csvf_pkg::t_stage         n_st [csvf_pkg::NST];

    function automatic csvf_pkg::t_sqrt sq_step(input csvf_pkg::t_sqrt s, input int i);
        csvf_pkg::t_sqrt      r;
        logic [csvf_pkg::SQE:0] bitv;
        logic [csvf_pkg::SQE:0] trial;
        bitv  = (csvf_pkg::SQE + 1)'(1) << (csvf_pkg::SQE - 2 - 2 * i);
        trial = s.root + bitv;
        if ({1'b0, s.rem} >= trial) begin
            r.rem  = s.rem - trial[csvf_pkg::SQE-1:0];
            r.root = (s.root >> 1) + bitv;
        end else begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_scan   <= 8'd80;
            r_vig    <= 8'd60;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                csvf_pkg::CFG_ENABLE:   r_enable <= i_cfg.data[0];
                csvf_pkg::CFG_SCANLINE: r_scan   <= i_cfg.data[7:0];
                csvf_pkg::CFG_VIGNETTE: r_vig    <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ld[csvf_pkg::NST-1] = !r_v[csvf_pkg::NST-1] || o_pix.ready;
        for (int k = csvf_pkg::NST - 2; k >= 0; k--) begin
            ld[k] = !r_v[k] || ld[k+1];
        end
    end

    assign i_pix.ready     = ld[0];
    assign o_pix.valid     = r_v[csvf_pkg::NST-1];
    assign o_pix.pixel_out = r_st[csvf_pkg::NST-1].px;

    always_comb begin
        logic [csvf_pkg::XT_W-1:0]   cw;
        logic [csvf_pkg::XT_W-1:0]   cv;
        logic [csvf_pkg::XT_W-1:0]   ax;
        logic [csvf_pkg::YT_W-1:0]   rw;
        logic [csvf_pkg::YT_W-1:0]   rv;
        logic [csvf_pkg::YT_W-1:0]   ay;
        logic [7:0]                  keep;
        logic [7:0]                  cr;
        logic [7:0]                  cg;
        logic [7:0]                  cb;
        logic [2*csvf_pkg::AX_W-1:0] sqx;
        logic [2*csvf_pkg::AY_W-1:0] sqy;
        logic [csvf_pkg::PR_W-csvf_pkg::RS-1:0] q;
        logic [7:0]                  darken;
        csvf_pkg::t_sqrt             s;

        n_st[0]      = '0;
        n_st[0].orig = i_pix.pixel_in;
        cw = csvf_pkg::XT_W'(i_pix.col);
        cv = csvf_pkg::XT_W'(csvf_pkg::CX);
        ax = (cw >= cv) ? cw - cv : cv - cw;
        rw = csvf_pkg::YT_W'(i_pix.row);
        rv = csvf_pkg::YT_W'(csvf_pkg::CY);
        ay = (rw >= rv) ? rw - rv : rv - rw;
        n_st[0].ax = ax[csvf_pkg::AX_W-1:0];
        n_st[0].ay = ay[csvf_pkg::AY_W-1:0];
        keep = i_pix.row[0] ? 8'hFF : 8'hFF - r_scan;
        n_st[0].pr = {8'b0, i_pix.pixel_in[15:11]} * {5'b0, keep};
        n_st[0].pg = {8'b0, i_pix.pixel_in[10:5]} * {6'b0, keep};
        n_st[0].pb = {8'b0, i_pix.pixel_in[4:0]} * {5'b0, keep};

        n_st[1] = r_st[0];
        cr = csvf_pkg::div255(16'(r_st[0].pr));
        cg = csvf_pkg::div255(16'(r_st[0].pg));
        cb = csvf_pkg::div255(16'(r_st[0].pb));
        n_st[1].px = {cr[4:0], cg[5:0], cb[4:0]};
        sqx = (2 * csvf_pkg::AX_W)'(r_st[0].ax) * (2 * csvf_pkg::AX_W)'(r_st[0].ax);
        sqy = (2 * csvf_pkg::AY_W)'(r_st[0].ay) * (2 * csvf_pkg::AY_W)'(r_st[0].ay);
        n_st[1].dxs = sqx[csvf_pkg::DXS_W-1:0];
        n_st[1].dys = sqy[csvf_pkg::DYS_W-1:0];

        n_st[2]         = r_st[1];
        n_st[2].sq.rem  = csvf_pkg::SQE'(r_st[1].dxs) + csvf_pkg::SQE'(r_st[1].dys);
        n_st[2].sq.root = '0;

        for (int j = 0; j < csvf_pkg::SQ_STG; j++) begin
            n_st[csvf_pkg::ST_SQ0+j] = r_st[csvf_pkg::ST_SQ0+j-1];
            s = r_st[csvf_pkg::ST_SQ0+j-1].sq;
            for (int t = 0; t < 2; t++) begin
                if (2 * j + t < csvf_pkg::DIST_W) begin
                    s = sq_step(s, 2 * j + t);
                end
            end
            n_st[csvf_pkg::ST_SQ0+j].sq = s;
        end

        n_st[csvf_pkg::ST_MUL] = r_st[csvf_pkg::ST_MUL-1];
        n_st[csvf_pkg::ST_MUL].m255 =
            csvf_pkg::CMP_W'(r_st[csvf_pkg::ST_MUL-1].sq.root[csvf_pkg::DIST_W-1:0])
            * csvf_pkg::CMP_W'(8'hFF);
        n_st[csvf_pkg::ST_MUL].thr =
            csvf_pkg::CMP_W'({1'b0, r_vig} + 9'd1) * csvf_pkg::CMP_W'(csvf_pkg::MAXD);
        n_st[csvf_pkg::ST_MUL].dp =
            csvf_pkg::DP_W'(r_st[csvf_pkg::ST_MUL-1].sq.root[csvf_pkg::DIST_W-1:0])
            * csvf_pkg::DP_W'(r_vig);

        n_st[csvf_pkg::ST_CMP]      = r_st[csvf_pkg::ST_MUL];
        n_st[csvf_pkg::ST_CMP].cond = (r_vig != 8'hFF)
            && (r_st[csvf_pkg::ST_MUL].m255 >= r_st[csvf_pkg::ST_MUL].thr);
        n_st[csvf_pkg::ST_CMP].dq   = csvf_pkg::PR_W'(r_st[csvf_pkg::ST_MUL].dp)
            * csvf_pkg::PR_W'(csvf_pkg::RM);

        n_st[csvf_pkg::ST_SCL] = r_st[csvf_pkg::ST_CMP];
        q = r_st[csvf_pkg::ST_CMP].dq[csvf_pkg::PR_W-1:csvf_pkg::RS];
        darken = (q > (csvf_pkg::PR_W - csvf_pkg::RS)'(8'hFF)) ? 8'hFF : q[7:0];
        keep   = r_st[csvf_pkg::ST_CMP].cond ? 8'hFF - darken : 8'hFF;
        n_st[csvf_pkg::ST_SCL].pr = {8'b0, r_st[csvf_pkg::ST_CMP].px[15:11]} * {5'b0, keep};
        n_st[csvf_pkg::ST_SCL].pg = {8'b0, r_st[csvf_pkg::ST_CMP].px[10:5]} * {6'b0, keep};
        n_st[csvf_pkg::ST_SCL].pb = {8'b0, r_st[csvf_pkg::ST_CMP].px[4:0]} * {5'b0, keep};

        n_st[csvf_pkg::ST_OUT] = r_st[csvf_pkg::ST_SCL];
        cr = csvf_pkg::div255(16'(r_st[csvf_pkg::ST_SCL].pr));
        cg = csvf_pkg::div255(16'(r_st[csvf_pkg::ST_SCL].pg));
        cb = csvf_pkg::div255(16'(r_st[csvf_pkg::ST_SCL].pb));
        n_st[csvf_pkg::ST_OUT].px = r_enable ? {cr[4:0], cg[5:0], cb[4:0]}
                                             : r_st[csvf_pkg::ST_SCL].orig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < csvf_pkg::NST; k++) begin
                if (ld[k]) begin
                    r_v[k] <= (k == 0) ? i_pix.valid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < csvf_pkg::NST; k++) begin
            if (ld[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

endmodule

`default_nettype wire
